// ----- rtl/core/priority_task_selector_retry_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the priority task selector
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_SELECTOR_RETRY_UNIT_ASSERT_SVH
`define PRIORITY_TASK_SELECTOR_RETRY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PTS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pts assertion failed");

// Next-cycle implication, disabled in reset.
`define PTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pts assertion failed");

`endif

// ----- rtl/core/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Types and fixed field widths of the priority task selector.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int PRI_W     = 8;   // task priority
  localparam int RET_W     = 8;   // stored signed retry count
  localparam int IN_RET_W  = 7;   // retry count on an add word
  localparam int OUT_IDX_W = 4;   // index field of a result word

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_SELECT = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;

  typedef enum logic [1:0] {
    TS_WAIT = 2'd0,
    TS_BUSY = 2'd1,
    TS_DONE = 2'd2,
    TS_FAIL = 2'd3
  } task_state_t;

  typedef enum logic [1:0] {
    RES_OK     = 2'd0,
    RES_FULL   = 2'd1,
    RES_NONE   = 2'd2,
    RES_NOPEND = 2'd3
  } res_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_SEL,
    ST_RPT_RD,
    ST_RPT_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [PRI_W-1:0]        pri;
    task_state_t             st;
    logic signed [RET_W-1:0] ret;
  } entry_t;

  localparam logic signed [RET_W-1:0] RET_EXHAUSTED = '1;

endpackage

`default_nettype wire

// ----- rtl/core/pts_if.sv -----
// ----------------------------------------------------------------------------
// pts_req_if / pts_rsp_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pts_req_if
  import pts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [PRI_W-1:0]    priority_req;
  logic [IN_RET_W-1:0] retries;
  logic                succeeded;

  modport source (output valid, action, priority_req, retries, succeeded,
                  input ready);
  modport sink   (input valid, action, priority_req, retries, succeeded,
                  output ready);
endinterface

interface pts_rsp_if
  import pts_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [OUT_IDX_W-1:0]    entry_index;
  logic [PRI_W-1:0]        entry_priority;
  logic signed [RET_W-1:0] retries_left;

  modport source (output valid, status, entry_index, entry_priority, retries_left,
                  input ready);
  modport sink   (input valid, status, entry_index, entry_priority, retries_left,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/priority_task_selector_retry_unit.sv -----
// ----------------------------------------------------------------------------
// priority_task_selector_retry_unit
// Static priority task table with retry counts, one word at a time.
// ----------------------------------------------------------------------------
// The block holds up to NB_ENTRIES tasks (priority, state, signed retry
// count) in a single-port-read table. A request word either adds a waiting
// task (action 0), selects the first eligible task with the strictly highest
// nonzero priority and marks it in progress (action 1), or applies a pass or
// fail outcome to the pending task (action 2); action 3 is dropped with no
// result. Every other request gives exactly one result word. The block takes
// one request at a time and drops req.ready until its result is loaded into
// the output register; that register lets the next request in while the
// result still waits on rsp. A select runs a scan, which reads one table
// entry per cycle through the single read port and feeds it to the one
// shared compare unit. Table contents are undefined after reset; only
// entries below the fill count are ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_selector_retry_unit
  import pts_pkg::*;
#(
  parameter int NB_ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  pts_req_if.sink   req,
  pts_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(NB_ENTRIES);
  localparam int CNT_W = $clog2(NB_ENTRIES + 1);

  // sequencer
  state_t state, state_next;

  // table bookkeeping
  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] pend_idx;
  logic             pend_valid;

  // latched request operands
  logic [PRI_W-1:0]    op_pri;
  logic [IN_RET_W-1:0] op_ret;
  logic                op_succ;

  // scan: scan_cnt issues reads, cmp_* tracks the entry whose data is back
  logic [CNT_W-1:0]        scan_cnt;
  logic                    cmp_pend;
  logic [IDX_W-1:0]        cmp_idx;
  logic [IDX_W-1:0]        best_idx;
  logic [PRI_W-1:0]        best_pri;
  logic signed [RET_W-1:0] best_ret;

  // staged result, then the output register
  res_code_t               res_code;
  logic [IDX_W-1:0]        res_idx;
  logic [PRI_W-1:0]        res_pri;
  logic signed [RET_W-1:0] res_ret;
  logic                    rsp_valid;
  res_code_t               rsp_code;
  logic [IDX_W-1:0]        rsp_idx;
  logic [PRI_W-1:0]        rsp_pri;
  logic signed [RET_W-1:0] rsp_ret;

  // table ports and shared unit
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic             alu_take;
  entry_t           alu_upd;

  logic req_fire;
  logic rsp_free;
  logic scan_more;
  logic table_full;

  assign req_fire   = req.valid && req.ready;
  assign rsp_free   = !rsp_valid || rsp.ready;
  assign scan_more  = scan_cnt < entry_count;
  assign table_full = entry_count == CNT_W'(NB_ENTRIES);

  pts_ram #(
    .DEPTH (NB_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pts_alu u_alu (
    .ent       (ram_rdata),
    .best_pri  (best_pri),
    .succeeded (op_succ),
    .take      (alu_take),
    .upd       (alu_upd)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (req.action)
            ACT_ADD:    state_next = ST_ADD;
            ACT_SELECT: state_next = ST_SCAN;
            ACT_REPORT: state_next = ST_RPT_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD:    state_next = ST_RESP;
      // done once every entry has been issued and the last one compared
      ST_SCAN:   if (!scan_more && !cmp_pend) state_next = ST_SEL;
      ST_SEL:    state_next = ST_RESP;
      ST_RPT_RD: state_next = pend_valid ? ST_RPT_WR : ST_RESP;
      ST_RPT_WR: state_next = ST_RESP;
      ST_RESP:   if (rsp_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs: table ports and request ready
  // --------------------------------------------------------------------------
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = '{pri: best_pri, st: TS_BUSY, ret: best_ret};
    ram_raddr = scan_cnt[IDX_W-1:0];
    case (state)
      ST_IDLE: begin
        req.ready = !rst;
      end
      ST_ADD: begin
        ram_we    = !table_full;
        ram_waddr = entry_count[IDX_W-1:0];
        ram_wdata = '{pri: op_pri, st: TS_WAIT, ret: $signed({1'b0, op_ret})};
      end
      ST_SEL: begin
        ram_we = best_pri != '0;
      end
      ST_RPT_RD: begin
        ram_raddr = pend_idx;
      end
      ST_RPT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pend_idx;
        ram_wdata = alu_upd;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      pend_idx    <= '0;
      pend_valid  <= 1'b0;
      cmp_pend    <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ADD && !table_full) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (state == ST_SCAN) begin
        cmp_pend <= scan_more;
      end
      if (state == ST_SEL && best_pri != '0) begin
        pend_idx   <= best_idx;
        pend_valid <= 1'b1;
      end
      if (state == ST_RPT_WR) begin
        pend_valid <= 1'b0;
      end
      if (state == ST_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_pri   <= req.priority_req;
        op_ret   <= req.retries;
        op_succ  <= req.succeeded;
        scan_cnt <= '0;
        best_idx <= '0;
        best_pri <= '0;
        best_ret <= '0;
      end
      ST_ADD: begin
        if (table_full) begin
          res_code <= RES_FULL;
          res_idx  <= '0;
          res_pri  <= '0;
          res_ret  <= '0;
        end else begin
          res_code <= RES_OK;
          res_idx  <= entry_count[IDX_W-1:0];
          res_pri  <= op_pri;
          res_ret  <= $signed({1'b0, op_ret});
        end
      end
      ST_SCAN: begin
        if (scan_more) begin
          scan_cnt <= scan_cnt + CNT_W'(1);
          cmp_idx  <= scan_cnt[IDX_W-1:0];
        end
        // strict compare keeps the lowest index among equal priorities
        if (cmp_pend && alu_take) begin
          best_idx <= cmp_idx;
          best_pri <= ram_rdata.pri;
          best_ret <= ram_rdata.ret;
        end
      end
      ST_SEL: begin
        if (best_pri != '0) begin
          res_code <= RES_OK;
          res_idx  <= best_idx;
          res_pri  <= best_pri;
          res_ret  <= best_ret;
        end else begin
          res_code <= RES_NONE;
          res_idx  <= '0;
          res_pri  <= '0;
          res_ret  <= '0;
        end
      end
      ST_RPT_RD: begin
        res_code <= RES_NOPEND;
        res_idx  <= '0;
        res_pri  <= '0;
        res_ret  <= '0;
      end
      ST_RPT_WR: begin
        res_code <= RES_OK;
        res_idx  <= pend_idx;
        res_pri  <= alu_upd.pri;
        res_ret  <= alu_upd.ret;
      end
      ST_RESP: begin
        if (rsp_free) begin
          rsp_code <= res_code;
          rsp_idx  <= res_idx;
          rsp_pri  <= res_pri;
          rsp_ret  <= res_ret;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Result word
  // --------------------------------------------------------------------------
  logic [IDX_W+OUT_IDX_W-1:0] idx_ext;

  assign idx_ext            = {{OUT_IDX_W{1'b0}}, rsp_idx};
  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_code;
  assign rsp.entry_index    = idx_ext[OUT_IDX_W-1:0];
  assign rsp.entry_priority = rsp_pri;
  assign rsp.retries_left   = rsp_ret;

endmodule

`default_nettype wire

// ----- rtl/core/pts_ram.sv -----
// ----------------------------------------------------------------------------
// pts_ram
// Task table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ram
  import pts_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire entry_t                   wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/pts_alu.sv -----
// ----------------------------------------------------------------------------
// pts_alu
// Shared entry unit: eligibility/priority compare and retry update.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_alu
  import pts_pkg::*;
(
  input  wire entry_t           ent,
  input  wire logic [PRI_W-1:0] best_pri,
  input  wire logic             succeeded,
  output logic                  take,
  output entry_t                upd
);

  logic eligible;

  // failed tasks stay eligible while the retry count is not negative
  assign eligible = (ent.st == TS_WAIT) || ((ent.st == TS_FAIL) && !ent.ret[RET_W-1]);
  assign take     = eligible && (ent.pri > best_pri);

  always_comb begin
    upd.pri = ent.pri;
    if (succeeded) begin
      upd.st  = TS_DONE;
      upd.ret = RET_EXHAUSTED;
    end else begin
      upd.st  = TS_FAIL;
      upd.ret = (ent.ret == RET_EXHAUSTED) ? ent.ret : ent.ret - RET_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pts_checker.sv -----
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the priority task selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_task_selector_retry_unit_assert.svh"

module pts_checker
  import pts_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    req_valid,
  input wire logic                    req_ready,
  input wire logic [1:0]              req_action,
  input wire logic                    rsp_valid,
  input wire logic                    rsp_ready,
  input wire logic [1:0]              status,
  input wire logic [OUT_IDX_W-1:0]    entry_index,
  input wire logic [PRI_W-1:0]        entry_priority,
  input wire logic signed [RET_W-1:0] retries_left
);

  // a stalled result word holds
  `PTS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(status) && $stable(entry_index) && $stable(entry_priority) && $stable(retries_left))

  // one word in flight: ready drops right after a request that gets a result is taken;
  // the unused action code is dropped and leaves ready up
  `PTS_ASSERT_NEXT(a_one_at_a_time, clk, rst,
    req_valid && req_ready &&
    (req_action == ACT_ADD || req_action == ACT_SELECT || req_action == ACT_REPORT),
    !req_ready)

  // every error result carries an all-zero task
  `PTS_ASSERT_NOW(a_err_zero, clk, rst, rsp_valid && status != RES_OK,
    entry_index == '0 && entry_priority == '0 && retries_left == '0)

  // retry count saturates at -1
  `PTS_ASSERT_NOW(a_ret_floor, clk, rst, rsp_valid && retries_left[RET_W-1],
    retries_left == RET_EXHAUSTED)

endmodule

bind priority_task_selector_retry_unit pts_checker u_pts_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_action     (req.action),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .status         (rsp.status),
  .entry_index    (rsp.entry_index),
  .entry_priority (rsp.entry_priority),
  .retries_left   (rsp.retries_left)
);

`default_nettype wire
